@@ src/membership_bitmap_engine_core_assert.svh @@
// assertion macros for the membership bitmap engine
// used by the top level; expects clk and rst in scope
`ifndef MEMBERSHIP_BITMAP_ENGINE_CORE_ASSERT_SVH
`define MEMBERSHIP_BITMAP_ENGINE_CORE_ASSERT_SVH

// plain property checked every cycle outside reset
`define MBE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cause in one cycle, effect in the next
`define MBE_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error(msg);

`endif

@@ src/mbe_pkg.sv @@
// shared types and constants for the membership bitmap engine
// no dependencies
`timescale 1ns / 1ps

package mbe_pkg;

  localparam int ID_W = 17;

  typedef enum logic [2:0] {
    OP_SET_RANGE = 3'd0,
    OP_OR_BYTE   = 3'd1,
    OP_TEST      = 3'd2,
    OP_FIND      = 3'd3,
    OP_TRIM      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic ex;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic load_empty;
    logic last;
    logic out_free;
  } sts_t;

endpackage

@@ src/membership_bitmap_engine_core.sv @@
// membership bitmap engine: one result word per input word, each bitmap word walked takes a read and an exec state
// an op with nothing to walk goes from accept straight to done, else read and exec repeat for each word visited
// a new input word is taken only in idle, after the previous result has been pushed to the output register
// set range, or byte, find next and trim visit words one at a time through the single memory port
// after rst a clearing pass zeroes every bitmap word in turn, with no input taken
// total_ids and the active count reset to zero
`timescale 1ns / 1ps

module membership_bitmap_engine_core #(
  parameter int STORE_WORDS = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata,  // total_ids
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,    // first_id, end_id, mask_byte
  input  logic [2:0]  s_tuser,    // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // found, result_id
);
  import mbe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mbe_datapath #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

`include "membership_bitmap_engine_core_assert.svh"

  `MBE_ASSERT(a_no_accept_in_clear, !(cmd.clr && s_tready), "input taken during clear")
  `MBE_ASSERT(a_push_not_ready, !(cmd.push && s_tready), "result pushed while taking input")
  `MBE_ASSERT_NEXT(a_exec_then_read, cmd.ex, !cmd.ex, "exec without a fresh read")

endmodule

@@ src/mbe_ctrl.sv @@
// controller state machine for the membership bitmap engine
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  mbe_pkg::sts_t sts,
  output mbe_pkg::cmd_t cmd
);
  import mbe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sts.load_empty ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.ex     = 1'b1;
        state_next = sts.last ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ src/mbe_datapath.sv @@
// datapath for the membership bitmap engine: bitmap memory, word walker, result register
// depends on mbe_pkg
`timescale 1ns / 1ps

module mbe_datapath #(
  parameter int STORE_WORDS = 2048
) (
  input  logic          clk,
  input  logic          rst,
  input  mbe_pkg::cmd_t cmd,
  output mbe_pkg::sts_t sts,
  input  logic          cfg_we,
  input  logic [16:0]   cfg_wdata,
  input  logic [2:0]    s_tuser,
  input  logic [47:0]   s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [23:0]   m_tdata
);
  import mbe_pkg::*;

  localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam logic [21:0] CAP = 22'(STORE_WORDS * 32);

  logic [31:0] store [STORE_WORDS];

  logic [16:0]   total_ids;
  logic [16:0]   active_count;
  logic [AW-1:0] clr_addr;
  logic [2:0]    op;
  logic [17:0]   cur;
  logic [17:0]   lim_end;
  logic [63:0]   pat;
  logic [31:0]   rdata;
  logic          found;
  logic [16:0]   rid;

  logic [16:0] limit;
  logic [2:0]  in_op;
  logic [16:0] in_first;
  logic [16:0] in_end;
  logic [7:0]  in_mask;
  logic [17:0] byte_end;
  logic [17:0] ld_end;
  logic [17:0] ld_cur;
  logic        ld_empty;

  logic        is_trim;
  logic        wr_op;
  logic [17:0] cur_m1;
  logic [17:0] base;
  logic [17:0] base_nx;
  logic [17:0] end_eff;
  logic [17:0] span;
  logic [4:0]  lo;
  logic [5:0]  hi;
  logic [31:0] wmask;
  logic [31:0] hit_word;
  logic        hit;
  logic [4:0]  first_off;
  logic [4:0]  last_off;
  logic [AW-1:0] addr;
  logic [31:0] pat_word;
  logic        walk_end;
  logic        last;
  logic [17:0] trim_id;
  logic [17:0] find_id;

  assign limit = ({5'b0, total_ids} < CAP) ? total_ids : 17'(CAP);

  assign in_op    = s_tuser;
  assign in_first = s_tdata[16:0];
  assign in_end   = s_tdata[33:17];
  assign in_mask  = s_tdata[41:34];
  assign byte_end = {1'b0, in_first} + 18'd8;

  always_comb begin
    ld_cur   = {1'b0, in_first};
    ld_end   = {1'b0, limit};
    ld_empty = 1'b1;
    unique case (in_op)
      OP_SET_RANGE: begin
        ld_end   = (in_end < limit) ? {1'b0, in_end} : {1'b0, limit};
        ld_empty = {1'b0, in_first} >= ld_end;
      end
      OP_OR_BYTE: begin
        ld_end   = (byte_end < {1'b0, limit}) ? byte_end : {1'b0, limit};
        ld_empty = {1'b0, in_first} >= ld_end;
      end
      OP_TEST: begin
        ld_end   = {1'b0, in_first} + 18'd1;
        ld_empty = in_first >= limit;
      end
      OP_FIND: begin
        ld_end   = (active_count < limit) ? {1'b0, active_count} : {1'b0, limit};
        ld_empty = {1'b0, in_first} >= ld_end;
      end
      OP_TRIM: begin
        ld_cur   = {1'b0, limit};
        ld_empty = limit == 17'd0;
      end
      default: begin
        ld_empty = 1'b1;
      end
    endcase
  end

  // word walker: forward from cur up to lim_end, or backward below cur for trim
  assign is_trim  = op == OP_TRIM;
  assign wr_op    = (op == OP_SET_RANGE) || (op == OP_OR_BYTE);
  assign cur_m1   = cur - 18'd1;
  assign base     = is_trim ? {cur_m1[17:5], 5'b0} : {cur[17:5], 5'b0};
  assign base_nx  = base + 18'd32;
  assign end_eff  = is_trim ? cur : lim_end;
  assign span     = end_eff - base;
  assign lo       = is_trim ? 5'd0 : cur[4:0];
  assign hi       = (end_eff >= base_nx) ? 6'd32 : span[5:0];
  assign wmask    = (32'hFFFF_FFFF >> lo) & ~(32'hFFFF_FFFF >> hi);
  assign hit_word = rdata & wmask;
  assign hit      = |hit_word;
  assign addr     = AW'(base >> 5);
  assign pat_word = (op == OP_OR_BYTE) ? pat[63:32] : 32'hFFFF_FFFF;
  assign walk_end = base_nx >= end_eff;
  assign trim_id  = base + {13'b0, last_off} + 18'd1;
  assign find_id  = base + {13'b0, first_off};

  always_comb begin
    first_off = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (hit_word[i]) begin
        first_off = 5'(31 - i);
      end
    end
  end

  always_comb begin
    last_off = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (hit_word[i]) begin
        last_off = 5'(31 - i);
      end
    end
  end

  always_comb begin
    unique case (op)
      OP_SET_RANGE, OP_OR_BYTE: last = walk_end;
      OP_TEST:                  last = 1'b1;
      OP_FIND:                  last = hit || walk_end;
      OP_TRIM:                  last = hit || (base == 18'd0);
      default:                  last = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      store[clr_addr] <= 32'd0;
    end else if (cmd.ex && wr_op) begin
      store[addr] <= rdata | (pat_word & wmask);
    end
    if (cmd.rd) begin
      rdata <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_ids    <= '0;
      active_count <= '0;
      clr_addr     <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_ids <= cfg_wdata;
      end
      if (cmd.clr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.load && (in_op == OP_TRIM)) begin
        active_count <= '0;
      end else if (cmd.ex && is_trim && hit) begin
        active_count <= trim_id[16:0];
      end
      if (cmd.push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_op;
      cur     <= ld_cur;
      lim_end <= ld_end;
      pat     <= {in_mask, 56'b0} >> in_first[4:0];
      found   <= 1'b0;
      rid     <= '0;
    end else if (cmd.ex) begin
      cur <= is_trim ? base : base_nx;
      pat <= pat << 32;
      unique case (op)
        OP_TEST: begin
          found <= hit;
        end
        OP_FIND: begin
          if (hit) begin
            found <= 1'b1;
            rid   <= find_id[16:0];
          end
        end
        OP_TRIM: begin
          if (hit) begin
            rid <= trim_id[16:0];
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.push) begin
      m_tdata <= {6'b0, rid, found};
    end
  end

  assign sts.clr_last   = clr_addr == AW'(STORE_WORDS - 1);
  assign sts.load_empty = ld_empty;
  assign sts.last       = last;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule
